// ===== sv/sxpd_pkg.sv =====
// ----------------------------------------------------------------------------
// sxpd_pkg
// Types and constants shared by the sync-byte packet deframer files.
// ----------------------------------------------------------------------------
package sxpd_pkg;

  // Register and field widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned TICKS_W     = 20;
  localparam int unsigned COLOUR_W    = 24;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned PAYLOAD_LEN = 8;
  localparam int unsigned PAY_IDX_W   = $clog2(PAYLOAD_LEN);
  localparam int unsigned PAY_CNT_W   = PAY_IDX_W + 1;

  // Configuration reset values
  localparam logic [BYTE_W-1:0]  SYNC_RESET    = 8'hAA;
  localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 20'd100000;
  localparam logic [TICKS_W-1:0] HOLD_RESET    = 20'd500000;

  // Status colours, GRB packed
  localparam logic [COLOUR_W-1:0] COLOUR_GOOD = 24'hFF0000;
  localparam logic [COLOUR_W-1:0] COLOUR_ERR  = 24'h00FF00;
  localparam logic [COLOUR_W-1:0] COLOUR_IDLE = 24'h101010;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC    = 2'd0,
    CFG_TIMEOUT = 2'd1,
    CFG_HOLD    = 2'd2
  } cfg_idx_e;

  // Request kinds
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // Result codes
  typedef enum logic [1:0] {
    EV_GOOD    = 2'd0,
    EV_TIMEOUT = 2'd1,
    EV_BADSUM  = 2'd2,
    EV_IDLE    = 2'd3
  } ev_code_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  sync_value;
    logic [TICKS_W-1:0] packet_timeout_ticks;
    logic [TICKS_W-1:0] led_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]           event_res;
    logic signed [7:0]    motor_0;
    logic signed [7:0]    motor_1;
    logic signed [7:0]    motor_2;
    logic signed [7:0]    motor_3;
    logic signed [7:0]    motor_4;
    logic signed [7:0]    motor_5;
    logic signed [7:0]    motor_6;
    logic signed [7:0]    motor_7;
    logic [COLOUR_W-1:0]  led_colour;
  } out_t;

endpackage

// ===== sv/sxpd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sxpd_cfg_regs
// Configuration registers: sync byte, packet timeout and colour hold time.
// ----------------------------------------------------------------------------
module sxpd_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sxpd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sxpd_pkg::TICKS_W-1:0]         cfg_wdata_i,
  output sxpd_pkg::cfg_t                       cfg_o
);
  import sxpd_pkg::*;

  cfg_t cfg_q;

  // Write decode; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_value           <= SYNC_RESET;
      cfg_q.packet_timeout_ticks <= TIMEOUT_RESET;
      cfg_q.led_hold_ticks       <= HOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC:    cfg_q.sync_value           <= cfg_wdata_i[BYTE_W-1:0];
        CFG_TIMEOUT: cfg_q.packet_timeout_ticks <= cfg_wdata_i;
        CFG_HOLD:    cfg_q.led_hold_ticks       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/sxpd_core.sv =====
// ----------------------------------------------------------------------------
// sxpd_core
// Deframer state: sync hunt, payload gather with running XOR, packet timer
// and colour hold timer. Produces at most one result per accepted request.
// ----------------------------------------------------------------------------
module sxpd_core #(
  parameter int unsigned TICK_COUNTER_WIDTH = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sxpd_pkg::cfg_t   cfg_i,
  input  logic             accept_i,
  input  sxpd_pkg::in_t    in_data_i,
  output logic             push_o,
  output sxpd_pkg::out_t   push_data_o
);
  import sxpd_pkg::*;

  localparam int unsigned W  = TICK_COUNTER_WIDTH;
  localparam int unsigned CW = (W > TICKS_W) ? W : TICKS_W;
  localparam logic [W-1:0] CNT_MAX = {W{1'b1}};

  logic                 gathering_q, gathering_d;
  logic [PAY_CNT_W-1:0] count_q, count_d;
  logic [BYTE_W-1:0]    xor_q, xor_d;
  logic [W-1:0]         elapsed_q, elapsed_d;
  logic                 hold_active_q, hold_active_d;
  logic [W-1:0]         hold_q, hold_d;
  logic [BYTE_W-1:0]    store_q [PAYLOAD_LEN];
  logic                 store_we;

  logic [W-1:0]  elapsed_inc;
  logic          timeout_hit;
  logic [CW-1:0] hold_cfg_ext;
  logic [W-1:0]  hold_load;
  logic [W-1:0]  hold_dec;
  logic          good;
  logic [1:0]    ev;
  logic [COLOUR_W-1:0] colour;

  // Timer arithmetic
  always_comb begin
    elapsed_inc  = (elapsed_q != CNT_MAX) ? elapsed_q + W'(1) : elapsed_q;
    timeout_hit  = gathering_q &&
                   ((CW'(elapsed_inc) >= CW'(cfg_i.packet_timeout_ticks)) ||
                    (elapsed_inc == CNT_MAX));
    hold_cfg_ext = CW'(cfg_i.led_hold_ticks);
    hold_load    = (hold_cfg_ext > CW'(CNT_MAX)) ? CNT_MAX : W'(hold_cfg_ext);
    hold_dec     = (hold_q != '0) ? hold_q - W'(1) : hold_q;
  end

  // Next state and result selection
  always_comb begin
    gathering_d   = gathering_q;
    count_d       = count_q;
    xor_d         = xor_q;
    elapsed_d     = elapsed_q;
    hold_active_d = hold_active_q;
    hold_d        = hold_q;
    store_we      = 1'b0;
    push_o        = 1'b0;
    good          = 1'b0;
    ev            = EV_IDLE;
    colour        = COLOUR_IDLE;
    if (accept_i) begin
      if (in_data_i.op == OP_BYTE) begin
        if (!gathering_q) begin
          // sync hunt
          if (in_data_i.rx_byte == cfg_i.sync_value) begin
            gathering_d = 1'b1;
            count_d     = '0;
            xor_d       = '0;
            elapsed_d   = '0;
          end
        end else if (count_q < PAY_CNT_W'(PAYLOAD_LEN)) begin
          // payload byte
          store_we = 1'b1;
          xor_d    = xor_q ^ in_data_i.rx_byte;
          count_d  = count_q + PAY_CNT_W'(1);
        end else begin
          // check byte
          gathering_d   = 1'b0;
          count_d       = '0;
          hold_active_d = 1'b1;
          hold_d        = hold_load;
          push_o        = 1'b1;
          if (xor_q == in_data_i.rx_byte) begin
            good   = 1'b1;
            ev     = EV_GOOD;
            colour = COLOUR_GOOD;
          end else begin
            ev     = EV_BADSUM;
            colour = COLOUR_ERR;
          end
        end
      end else begin
        // time tick
        if (gathering_q) begin
          elapsed_d = elapsed_inc;
        end
        if (timeout_hit) begin
          gathering_d   = 1'b0;
          count_d       = '0;
          hold_active_d = 1'b1;
          hold_d        = hold_load;
          push_o        = 1'b1;
          ev            = EV_TIMEOUT;
          colour        = COLOUR_ERR;
        end else if (hold_active_q) begin
          hold_d = hold_dec;
          if (hold_dec == '0) begin
            hold_active_d = 1'b0;
            push_o        = 1'b1;
            ev            = EV_IDLE;
            colour        = COLOUR_IDLE;
          end
        end
      end
    end
  end

  // Result payload; motors only on a good packet
  always_comb begin
    push_data_o.event_res  = ev;
    push_data_o.motor_0    = good ? $signed(store_q[0]) : '0;
    push_data_o.motor_1    = good ? $signed(store_q[1]) : '0;
    push_data_o.motor_2    = good ? $signed(store_q[2]) : '0;
    push_data_o.motor_3    = good ? $signed(store_q[3]) : '0;
    push_data_o.motor_4    = good ? $signed(store_q[4]) : '0;
    push_data_o.motor_5    = good ? $signed(store_q[5]) : '0;
    push_data_o.motor_6    = good ? $signed(store_q[6]) : '0;
    push_data_o.motor_7    = good ? $signed(store_q[7]) : '0;
    push_data_o.led_colour = colour;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gathering_q   <= 1'b0;
      count_q       <= '0;
      xor_q         <= '0;
      elapsed_q     <= '0;
      hold_active_q <= 1'b0;
      hold_q        <= '0;
    end else begin
      gathering_q   <= gathering_d;
      count_q       <= count_d;
      xor_q         <= xor_d;
      elapsed_q     <= elapsed_d;
      hold_active_q <= hold_active_d;
      hold_q        <= hold_d;
    end
  end

  // Payload store, filled in order before every check byte
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q[PAY_IDX_W-1:0]] <= in_data_i.rx_byte;
    end
  end

endmodule

// ===== sv/sxpd_outbuf.sv =====
// ----------------------------------------------------------------------------
// sxpd_outbuf
// Result register with a skid stage, so a request is taken while a result
// still waits downstream.
// ----------------------------------------------------------------------------
module sxpd_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sxpd_pkg::out_t   push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sxpd_pkg::out_t   out_data_o
);
  import sxpd_pkg::*;

  logic main_valid_q, skid_valid_q;
  out_t main_q, skid_q;
  logic pop;

  assign pop = main_valid_q && !out_stall_i;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q || pop) begin
      main_valid_q <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload; no push happens while the skid stage is occupied
  always_ff @(posedge clk_i) begin
    if (!main_valid_q || pop) begin
      main_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

// ===== sv/sync_xor_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// sync_xor_packet_deframer_unit
// A result is registered; it waits in the skid stage if the result register is held.
// Throughput: one request per cycle while the input is not stalled; the state update is a single pass.
// Input stalls only when both the result register and the skid stage hold
// results that downstream has not taken.
// Reset: asynchronous, active low; registers return to their reset values,
// no results pending, sync hunt idle, colour timer off.
// ----------------------------------------------------------------------------
module sync_xor_packet_deframer_unit #(
  parameter int unsigned TICK_COUNTER_WIDTH = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sxpd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sxpd_pkg::TICKS_W-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  sxpd_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output sxpd_pkg::out_t                    out_data_o
);
  import sxpd_pkg::*;

  cfg_t cfg;
  logic accept;
  logic push;
  logic full;
  out_t push_data;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  sxpd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sxpd_core #(
    .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sxpd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/sxpd_checker.sv =====
// ----------------------------------------------------------------------------
// sxpd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sxpd_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_stall_o,
  input  logic             out_valid_o,
  input  logic             out_stall_i,
  input  sxpd_pkg::out_t   out_data_o
);
  import sxpd_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // Colour follows the result code
  a_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_data_o.event_res == EV_GOOD) && (out_data_o.led_colour == COLOUR_GOOD)) ||
      ((out_data_o.event_res == EV_TIMEOUT) && (out_data_o.led_colour == COLOUR_ERR)) ||
      ((out_data_o.event_res == EV_BADSUM) && (out_data_o.led_colour == COLOUR_ERR)) ||
      ((out_data_o.event_res == EV_IDLE) && (out_data_o.led_colour == COLOUR_IDLE)))
    else $error("colour does not match result code");

  // Motor fields are zero outside a good packet
  a_motor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_res != EV_GOOD) |->
      (out_data_o.motor_0 == '0) && (out_data_o.motor_1 == '0) &&
      (out_data_o.motor_2 == '0) && (out_data_o.motor_3 == '0) &&
      (out_data_o.motor_4 == '0) && (out_data_o.motor_5 == '0) &&
      (out_data_o.motor_6 == '0) && (out_data_o.motor_7 == '0))
    else $error("motor fields set on a non-good result");

  // Input backpressure only with a result pending
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind sync_xor_packet_deframer_unit sxpd_checker u_sxpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the sync-byte packet deframer. A short table of directed requests
// runs first, then random traffic in phases with different register settings
// and idle patterns. Every result is compared field by field against an
// in-bench predictor of the deframer state.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sxpd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam logic [TICKS_W-1:0] CNT_MAX = '1;
  // Index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_TICK,
    ROW_WR
  } row_kind_e;

  // One line of the directed table; want_* used only when typed is set
  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [TICKS_W-1:0]   data;
    bit                   typed;
    ev_code_e             want_ev;
    logic [COLOUR_W-1:0]  want_colour;
  } plan_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [TICKS_W-1:0]   cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_t                 out_data_o;

  // Predictor copy of registers and deframer state
  logic [BYTE_W-1:0]    sync_reg;
  logic [TICKS_W-1:0]   timeout_reg;
  logic [TICKS_W-1:0]   hold_reg;
  bit                   gathering;
  logic [PAY_CNT_W-1:0] nbytes;
  logic [BYTE_W-1:0]    xor_acc;
  logic [BYTE_W-1:0]    payload_q [PAYLOAD_LEN];
  logic [TICKS_W-1:0]   elapsed;
  bit                   hold_on;
  logic [TICKS_W-1:0]   hold_left;

  out_t        pending_events [$];
  int unsigned mismatches;
  int unsigned reqs_sent;
  int unsigned ev_count [4];
  int unsigned cycles;
  int          snd_idle_pct;
  int          rcv_idle_pct;

  plan_row_t plan [$] = '{
    // byte before any sync is dropped, lone tick does nothing
    '{ROW_BYTE, CFG_SYNC, 20'h00, 1'b0, EV_GOOD, '0},
    '{ROW_TICK, CFG_SYNC, 20'h00, 1'b0, EV_GOOD, '0},
    // good packet with extreme payload values and the sync byte inside
    '{ROW_BYTE, CFG_SYNC, 20'hAA, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'h00, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'hFF, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'h80, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'h7F, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'h01, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'hAA, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'h55, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'hFE, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'h00, 1'b1, EV_GOOD, COLOUR_GOOD},
    // payload XOR is 0x00, check byte 0x01 is wrong
    '{ROW_BYTE, CFG_SYNC, 20'hAA, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'h12, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'h34, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'h56, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'h78, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'h9A, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'hBC, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'hDE, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'hF0, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'h01, 1'b1, EV_BADSUM, COLOUR_ERR},
    // short limits: timeout on the second tick, then hold of one tick
    '{ROW_WR,   CFG_TIMEOUT, 20'd2, 1'b0, EV_GOOD, '0},
    '{ROW_WR,   CFG_HOLD,    20'd1, 1'b0, EV_GOOD, '0},
    '{ROW_BYTE, CFG_SYNC, 20'hAA, 1'b0, EV_GOOD, '0},
    '{ROW_TICK, CFG_SYNC, 20'h00, 1'b0, EV_GOOD, '0},
    '{ROW_TICK, CFG_SYNC, 20'h00, 1'b1, EV_TIMEOUT, COLOUR_ERR},
    '{ROW_TICK, CFG_SYNC, 20'h00, 1'b1, EV_IDLE, COLOUR_IDLE},
    // write to an unused index changes nothing
    '{ROW_WR,   CFG_UNUSED, 20'hFFFFF, 1'b0, EV_GOOD, '0}
  };

  sync_xor_packet_deframer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_events.size());
      $display("[sync_xor_packet_deframer_unit] ERROR");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= (rcv_idle_pct > 0) && ($urandom_range(0, 99) < rcv_idle_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_event(out_data_o);
    end
  end

  // Status colour goes on hold after each packet outcome
  function automatic void load_hold();
    hold_left = hold_reg;
    hold_on   = 1'b1;
  endfunction

  // Deframer state update for one accepted request; returns 1 with a result
  function automatic bit deframe_step(input in_t req, output out_t res);
    res = '0;
    if (req.op == OP_BYTE) begin
      if (!gathering) begin
        if (req.rx_byte == sync_reg) begin
          gathering = 1'b1;
          nbytes    = '0;
          xor_acc   = '0;
          elapsed   = '0;
        end
        return 1'b0;
      end
      if (nbytes < PAYLOAD_LEN) begin
        payload_q[nbytes[PAY_IDX_W-1:0]] = req.rx_byte;
        xor_acc ^= req.rx_byte;
        nbytes++;
        return 1'b0;
      end
      // check byte closes the packet
      gathering = 1'b0;
      nbytes    = '0;
      load_hold();
      if (xor_acc == req.rx_byte) begin
        res.event_res  = EV_GOOD;
        res.motor_0    = payload_q[0];
        res.motor_1    = payload_q[1];
        res.motor_2    = payload_q[2];
        res.motor_3    = payload_q[3];
        res.motor_4    = payload_q[4];
        res.motor_5    = payload_q[5];
        res.motor_6    = payload_q[6];
        res.motor_7    = payload_q[7];
        res.led_colour = COLOUR_GOOD;
      end else begin
        res.event_res  = EV_BADSUM;
        res.led_colour = COLOUR_ERR;
      end
      return 1'b1;
    end
    // tick: packet timer first, it wins over hold expiry
    if (gathering) begin
      if (elapsed != CNT_MAX) elapsed++;
      if (elapsed >= timeout_reg || elapsed == CNT_MAX) begin
        gathering = 1'b0;
        nbytes    = '0;
        load_hold();
        res.event_res  = EV_TIMEOUT;
        res.led_colour = COLOUR_ERR;
        return 1'b1;
      end
    end
    if (hold_on) begin
      if (hold_left != 0) hold_left--;
      if (hold_left == 0) begin
        hold_on        = 1'b0;
        res.event_res  = EV_IDLE;
        res.led_colour = COLOUR_IDLE;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic check_event(input out_t got);
    out_t               want;
    logic [8*BYTE_W-1:0] mw;
    logic [8*BYTE_W-1:0] mg;
    if (pending_events.size() == 0) begin
      $display("%0t: unexpected result event_res=%0d", $time, got.event_res);
      mismatches++;
      return;
    end
    want = pending_events.pop_front();
    ev_count[want.event_res]++;
    if (got.event_res !== want.event_res) begin
      $display("%0t: event_res expected %0d got %0d", $time, want.event_res,
               got.event_res);
      mismatches++;
    end
    mw = {want.motor_0, want.motor_1, want.motor_2, want.motor_3,
          want.motor_4, want.motor_5, want.motor_6, want.motor_7};
    mg = {got.motor_0, got.motor_1, got.motor_2, got.motor_3,
          got.motor_4, got.motor_5, got.motor_6, got.motor_7};
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      if (mg[8*BYTE_W-1-BYTE_W*i -: BYTE_W] !== mw[8*BYTE_W-1-BYTE_W*i -: BYTE_W]) begin
        $display("%0t: motor_%0d expected %0d got %0d", $time, i,
                 $signed(mw[8*BYTE_W-1-BYTE_W*i -: BYTE_W]),
                 $signed(mg[8*BYTE_W-1-BYTE_W*i -: BYTE_W]));
        mismatches++;
      end
    end
    if (got.led_colour !== want.led_colour) begin
      $display("%0t: led_colour expected %06h got %06h", $time, want.led_colour,
               got.led_colour);
      mismatches++;
    end
  endtask

  // Drive one request at a falling edge; returns at a falling edge.
  // Valid is left high so the next request can follow back to back.
  task automatic send_req(input in_t req, input bit typed = 1'b0,
                          input ev_code_e want_ev = EV_GOOD,
                          input logic [COLOUR_W-1:0] want_colour = '0);
    out_t res;
    bit   made;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    made = deframe_step(req, res);
    if (typed) begin
      if (!made) res = '0;
      res.event_res  = want_ev;
      res.led_colour = want_colour;
      made = 1'b1;
    end
    if (made) pending_events.push_back(res);
    reqs_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    in_t req;
    req.op      = OP_BYTE;
    req.rx_byte = b;
    send_req(req);
  endtask

  // Byte field is don't-care on ticks, so keep it random
  task automatic send_ticks(input int unsigned n);
    in_t req;
    repeat (n) begin
      req.op      = OP_TICK;
      req.rx_byte = BYTE_W'($urandom_range(0, 255));
      send_req(req);
    end
  endtask

  // Hold requests off until every result is in, then let the block settle
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [TICKS_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_SYNC:    sync_reg    = data[BYTE_W-1:0];
      CFG_TIMEOUT: timeout_reg = data;
      CFG_HOLD:    hold_reg    = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random traffic: mostly framed packets with random content, some noise
  task automatic run_phase(input logic [BYTE_W-1:0] sync_v,
                           input logic [TICKS_W-1:0] timeout_v,
                           input logic [TICKS_W-1:0] hold_v,
                           input int unsigned n_reqs,
                           input int snd_pct, input int rcv_pct);
    int unsigned       stop_at;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] pb;
    int                pick;
    wait_drain();
    write_reg(CFG_SYNC, {12'h000, sync_v});
    write_reg(CFG_TIMEOUT, timeout_v);
    write_reg(CFG_HOLD, hold_v);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    stop_at = reqs_sent + n_reqs;
    while (reqs_sent < stop_at) begin
      if ($urandom_range(0, 3) != 0) begin
        send_byte(sync_v);
        sum = '0;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
          if ($urandom_range(0, 5) == 0) send_ticks($urandom_range(1, 3));
          pb = BYTE_W'($urandom_range(0, 255));
          sum ^= pb;
          send_byte(pb);
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) send_byte(sum);
        else if (pick < 85) send_byte(sum ^ (8'h01 << $urandom_range(0, 7)));
        else send_ticks($urandom_range(1, 30)); // abandoned packet
      end else if ($urandom_range(0, 1) == 0) begin
        send_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
        // long bursts let the status hold run out
        send_ticks(($urandom_range(0, 3) == 0) ? $urandom_range(8, 60)
                                                : $urandom_range(1, 4));
      end
    end
  endtask

  initial begin
    in_t req;
    sync_reg     = SYNC_RESET;
    timeout_reg  = TIMEOUT_RESET;
    hold_reg     = HOLD_RESET;
    gathering    = 1'b0;
    nbytes       = '0;
    xor_acc      = '0;
    elapsed      = '0;
    hold_on      = 1'b0;
    hold_left    = '0;
    foreach (payload_q[i]) payload_q[i] = '0;
    snd_idle_pct = 18;
    rcv_idle_pct = 74;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, starting from reset register values
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WR) begin
        wait_drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        req.op      = (plan[i].kind == ROW_TICK) ? OP_TICK : OP_BYTE;
        req.rx_byte = plan[i].data[BYTE_W-1:0];
        send_req(req, plan[i].typed, plan[i].want_ev, plan[i].want_colour);
      end
    end

    // Random phases: sender light / receiver heavy, swapped, then no idling
    run_phase(8'h00, 20'd1, 20'd1, 180, 18, 74);
    run_phase(8'hFF, 20'd12, 20'd5, 180, 18, 74);
    run_phase(BYTE_W'($urandom_range(0, 255)), 20'd20, 20'd40, 180, 74, 18);
    run_phase(8'h5A, CNT_MAX, CNT_MAX, 100, 74, 18);
    run_phase(BYTE_W'($urandom_range(0, 255)), TICKS_W'($urandom_range(5, 30)),
              TICKS_W'($urandom_range(1, 30)), 260, 0, 0);

    wait_drain();
    repeat (10) @(negedge clk_i);
    if (pending_events.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_events.size());
      mismatches++;
    end

    $display("%0d requests over five register settings; results: %0d good, %0d bad sum,",
             reqs_sent, ev_count[EV_GOOD], ev_count[EV_BADSUM]);
    $display("%0d timeout, %0d back to idle; %0d mismatches",
             ev_count[EV_TIMEOUT], ev_count[EV_IDLE], mismatches);
    if (mismatches == 0) begin
      $display("[sync_xor_packet_deframer_unit] OK");
    end else begin
      $display("[sync_xor_packet_deframer_unit] ERROR");
    end
    $finish;
  end

endmodule
